/* src/melt_pkg.sv */
// shared types and codes for the mac endpoint learning table
// no dependencies
package melt_pkg;

  localparam int unsigned AddrW = 48;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_DONE = 2'd1,
    ST_NEW  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // result record passed from the sequencer to the output stage
  typedef struct packed {
    logic             ok;
    status_t          status;
    logic [AddrW-1:0] ep;
  } result_t;

endpackage

/* src/mac_endpoint_learning_table.sv */
// top level of the mac endpoint learning table: sequencer and both memories
// depends on melt_pkg and melt_out
//
//  channel | ports                                  | handshake
//  request | in_operation, in_mac, in_endpoint      | start & !busy
//  result  | out_ok, out_status, out_found_endpoint | out_valid, one cycle
//
// sequence while busy, lookup: mac scan, then a destination read if the mac is found
// add: mac scan, destination read if the mac is present, endpoint scan, commit
// remove: mac scan alone if the mac is absent, else destination read, endpoint scan,
// a purge of the mac store when its endpoint is known, then commit; unused codes: mac scan
// each memory has one registered read port, which sets the scan rate
// valid bits are flip-flops cleared by reset, so no clearing pass is needed
// the receiver cannot stall; the result strobe comes in the first cycle with busy low,
// and the next request can be taken in that same cycle
module mac_endpoint_learning_table #(
  parameter int MAC_ENTRIES      = 64,
  parameter int ENDPOINT_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [47:0] in_mac,
  input  logic [47:0] in_endpoint,
  output logic        out_valid,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic [47:0] out_found_endpoint
);
  import melt_pkg::*;

  localparam int MW = $clog2(MAC_ENTRIES);
  localparam int EW = $clog2(ENDPOINT_ENTRIES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MSCAN = 7'b0000010,  // search mac store for key, first free slot
    S_ESCAN = 7'b0000100,  // search endpoint store
    S_DEST  = 7'b0001000,  // read dest of hit mac
    S_PURGE = 7'b0010000,  // remove: drop every mac with target endpoint
    S_COMMIT= 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // memories: key and destination per mac entry, key per endpoint entry
  logic [47:0] mac_key_mem  [MAC_ENTRIES];
  logic [47:0] mac_dest_mem [MAC_ENTRIES];
  logic [47:0] ep_key_mem   [ENDPOINT_ENTRIES];
  logic [MAC_ENTRIES-1:0]      mac_valid_r;
  logic [ENDPOINT_ENTRIES-1:0] ep_valid_r;

  // request latch
  op_t         op_r;
  logic [47:0] mac_r, ep_r;

  // scan pointers: issue address and the address whose data returns now
  logic [MW:0] mptr_r;
  logic [EW:0] eptr_r;
  logic [MW-1:0] mrd_idx_r;
  logic [EW-1:0] erd_idx_r;
  logic          mrd_v_r, erd_v_r;
  logic [47:0]   mkey_r, mdest_r, ekey_r;

  // search results
  logic          mhit_r, mfree_v_r, ehit_r, efree_v_r;
  logic [MW-1:0] midx_r, mfree_r;
  logic [EW-1:0] eidx_r, efree_r;
  logic [47:0]   target_r;

  result_t res_nxt;
  logic    fire;

  // memory writes and registered reads
  logic          mw_en, ew_en;
  logic [MW-1:0] mw_idx;
  logic [EW-1:0] ew_idx;

  always_ff @(posedge clk) begin
    if (mw_en) begin
      mac_key_mem[mw_idx]  <= mac_r;
      mac_dest_mem[mw_idx] <= ep_r;
    end
    if (ew_en) begin
      ep_key_mem[ew_idx] <= ep_r;
    end
    mkey_r  <= mac_key_mem[mptr_r[MW-1:0]];
    mdest_r <= mac_dest_mem[(state_r == S_DEST) ? midx_r : mptr_r[MW-1:0]];
    ekey_r  <= ep_key_mem[eptr_r[EW-1:0]];
  end

  // commit decisions for add
  logic add_full;
  assign add_full = (!mhit_r && !mfree_v_r) || (!ehit_r && !efree_v_r);

  always_comb begin
    mw_en  = 1'b0;
    ew_en  = 1'b0;
    mw_idx = mhit_r ? midx_r : mfree_r;
    ew_idx = efree_r;
    if (state_r == S_COMMIT && op_r == OP_ADD && !add_full) begin
      mw_en = 1'b1;
      ew_en = !ehit_r;
    end
  end

  logic mscan_end, escan_end, purge_end;
  assign mscan_end = mrd_v_r && mrd_idx_r == MW'(MAC_ENTRIES - 1);
  assign escan_end = erd_v_r && erd_idx_r == EW'(ENDPOINT_ENTRIES - 1);
  assign purge_end = mscan_end;

  // key hit including the comparison that lands in this cycle
  logic mhit_now;
  assign mhit_now = mhit_r || (mrd_v_r && mac_valid_r[mrd_idx_r] && mkey_r == mac_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_MSCAN;
      S_MSCAN:  if (mscan_end) begin
        case (op_r)
          OP_ADD:               state_nxt = mhit_now ? S_DEST : S_ESCAN;
          OP_LOOKUP, OP_REMOVE: state_nxt = mhit_now ? S_DEST : S_DONE;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_DEST:   state_nxt = (op_r == OP_LOOKUP) ? S_DONE : S_ESCAN;
      S_ESCAN:  if (escan_end) state_nxt = (op_r == OP_REMOVE) ? S_PURGE : S_COMMIT;
      S_PURGE:  if (!ehit_r || purge_end) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  logic [47:0] ekey_cmp;
  assign ekey_cmp = (op_r == OP_REMOVE) ? target_r : ep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mac_valid_r <= '0;
      ep_valid_r  <= '0;
      mrd_v_r     <= 1'b0;
      erd_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mw_en) mac_valid_r[mw_idx] <= 1'b1;
      if (ew_en) ep_valid_r[ew_idx]  <= 1'b1;
      // pipelined scan: pointer issues, read index follows in the next cycle
      mrd_v_r <= 1'b0;
      erd_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          mptr_r <= '0;
          eptr_r <= '0;
          if (start) begin
            op_r <= op_t'(in_operation);
            mac_r <= in_mac;
            ep_r <= in_endpoint;
            mhit_r <= 1'b0; mfree_v_r <= 1'b0;
            ehit_r <= 1'b0; efree_v_r <= 1'b0;
            midx_r <= '0; mfree_r <= '0; eidx_r <= '0; efree_r <= '0;
          end
        end
        S_MSCAN, S_PURGE: begin
          if (mptr_r < (MW+1)'(MAC_ENTRIES)) begin
            mrd_v_r   <= 1'b1;
            mrd_idx_r <= mptr_r[MW-1:0];
            mptr_r    <= mptr_r + 1'b1;
          end
          if (mrd_v_r) begin
            if (state_r == S_MSCAN) begin
              if (mac_valid_r[mrd_idx_r] && mkey_r == mac_r && !mhit_r) begin
                mhit_r <= 1'b1;
                midx_r <= mrd_idx_r;
              end
              if (!mac_valid_r[mrd_idx_r] && !mfree_v_r) begin
                mfree_v_r <= 1'b1;
                mfree_r   <= mrd_idx_r;
              end
            end else if (ehit_r && mac_valid_r[mrd_idx_r] && mdest_r == target_r) begin
              mac_valid_r[mrd_idx_r] <= 1'b0;
            end
          end
          if (state_nxt != state_r) mptr_r <= '0;
        end
        S_DEST: ;
        S_ESCAN: begin
          // first cycle: the hit entry's destination is on the read port
          if (eptr_r == '0 && !erd_v_r && !ehit_r)
            target_r <= mdest_r;
          if (eptr_r < (EW+1)'(ENDPOINT_ENTRIES)) begin
            erd_v_r   <= 1'b1;
            erd_idx_r <= eptr_r[EW-1:0];
            eptr_r    <= eptr_r + 1'b1;
          end
          if (erd_v_r) begin
            if (ep_valid_r[erd_idx_r] && ekey_r == ekey_cmp && !ehit_r) begin
              ehit_r <= 1'b1;
              eidx_r <= erd_idx_r;
            end
            if (!ep_valid_r[erd_idx_r] && !efree_v_r) begin
              efree_v_r <= 1'b1;
              efree_r   <= erd_idx_r;
            end
          end
          if (state_nxt != state_r) mptr_r <= '0;
        end
        S_COMMIT: begin
          if (op_r == OP_REMOVE && ehit_r) ep_valid_r[eidx_r] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // lookup takes the destination read in the dest cycle; add compares the old one
  always_comb begin
    res_nxt = '{ok: 1'b0, status: ST_NONE, ep: '0};
    case (op_r)
      OP_LOOKUP: if (mhit_r) res_nxt = '{ok: 1'b1, status: ST_DONE, ep: mdest_r};
      OP_ADD: begin
        if (add_full) begin
          res_nxt.status = ST_FULL;
        end else if (!mhit_r || !ehit_r) begin
          res_nxt.ok = 1'b1; res_nxt.status = ST_NEW;
        end else if (target_r != ep_r) begin
          res_nxt.ok = 1'b1; res_nxt.status = ST_DONE;
        end
      end
      OP_REMOVE: if (mhit_r && ehit_r) begin
        res_nxt.ok = 1'b1; res_nxt.status = ST_DONE;
      end
      default: ;
    endcase
  end

  assign fire = (state_r == S_DONE);
  assign busy = (state_r != S_IDLE);

  melt_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .res    (res_nxt),
    .strobe (out_valid),
    .ok     (out_ok),
    .status (out_status),
    .ep     (out_found_endpoint)
  );
endmodule

/* src/melt_out.sv */
// result register stage: one-cycle strobe with the result fields
// depends on melt_pkg
module melt_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  melt_pkg::result_t res,
  output logic              strobe,
  output logic              ok,
  output logic [1:0]        status,
  output logic [47:0]       ep
);
  import melt_pkg::*;

  logic    strobe_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= fire;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign strobe = strobe_r;
  assign ok     = res_r.ok;
  assign status = res_r.status;
  assign ep     = res_r.ep;
endmodule
